FILE: rtl/cumulative_sum_volume_macros.svh
// Assertion macros shared by the cumulative_sum_volume RTL.
// Needs clk and rst in scope at the point of use; no other dependencies.
`ifndef CUMULATIVE_SUM_VOLUME_MACROS_SVH
`define CUMULATIVE_SUM_VOLUME_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CSV_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("cumulative_sum_volume: check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define CSV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cumulative_sum_volume: implication failed");

`endif

FILE: rtl/csv_pkg.sv
// Shared types, constants and saturating arithmetic for cumulative_sum_volume.
// No dependencies; used by csv_front, csv_back and the top level.
`default_nettype none

package csv_pkg;

  localparam int SUM_W    = 48;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DEPTH = 4;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER  = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_OUTER  = 2'd2
  } cfg_reg_t;

  // Per-item flags carried from the front part to the back part.
  typedef struct packed {
    logic m_zero;
    logic o_zero;
    logic last;
  } item_flags_t;

  // Back part handshake status, watched by the top-level checks.
  typedef struct packed {
    logic pop;
    logic q_valid;
    logic out_push;
    logic out_room;
  } back_status_t;

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/csv_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module csv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/csv_fifo.sv
// Small flop-based FIFO with fill level; used as the front-to-back queue
// and as the output buffer. No dependencies.
`default_nettype none

module csv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [WIDTH-1:0]                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [WIDTH-1:0]                 out_data,
  output logic [$clog2(DEPTH+1)-1:0]       level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign level     = count;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csv_front.sv
// Front part: size registers, position counters and inner running sum.
// Depends on csv_pkg; feeds the front-to-back queue.
`default_nettype none

module csv_front #(
  parameter int MAX_INNER  = 256,
  parameter int MAX_MIDDLE = 256,
  parameter int MAX_OUTER  = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [csv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [csv_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   s_valid,
  output logic                                   s_ready,
  input  logic signed [csv_pkg::SAMPLE_W-1:0]    s_sample,
  input  logic                                   q_ready,
  output logic                                   q_valid,
  output csv_pkg::sum_t                          q_sum,
  output logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] q_i,
  output logic [((MAX_INNER*MAX_MIDDLE > 1) ? $clog2(MAX_INNER*MAX_MIDDLE) : 1)-1:0] q_addr,
  output csv_pkg::item_flags_t                   q_flags
);

  localparam int IPW   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int MPW   = (MAX_MIDDLE > 1) ? $clog2(MAX_MIDDLE) : 1;
  localparam int OPW   = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
  localparam int PAW   = (MAX_INNER*MAX_MIDDLE > 1) ? $clog2(MAX_INNER*MAX_MIDDLE) : 1;

  logic [csv_pkg::CFG_W-1:0] inner_size;
  logic [csv_pkg::CFG_W-1:0] middle_size;
  logic [csv_pkg::CFG_W-1:0] outer_size;
  csv_pkg::sum_t             run_sum;
  logic [IPW-1:0]            pos_i;
  logic [MPW-1:0]            pos_m;
  logic [OPW-1:0]            pos_o;

  logic [IPW-1:0]            last_i;
  logic [MPW-1:0]            last_m;
  logic [OPW-1:0]            last_o;
  logic [IPW-1:0]            pos_i_next;
  logic [MPW-1:0]            pos_m_next;
  logic [OPW-1:0]            pos_o_next;
  csv_pkg::sum_t             sample_ext;
  csv_pkg::sum_t             run_sum_next;
  logic                      cfg_hit;
  logic                      accept;

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic int last_index(input logic [csv_pkg::CFG_W-1:0] raw, input int limit);
    if (raw == '0) begin
      return 0;
    end
    if (int'(raw) > limit) begin
      return limit - 1;
    end
    return int'(raw) - 1;
  endfunction

  assign last_i = IPW'(last_index(inner_size, MAX_INNER));
  assign last_m = MPW'(last_index(middle_size, MAX_MIDDLE));
  assign last_o = OPW'(last_index(outer_size, MAX_OUTER));

  assign s_ready = q_ready;
  assign q_valid = s_valid;
  assign accept  = s_valid && q_ready;

  assign sample_ext   = {{(csv_pkg::SUM_W-csv_pkg::SAMPLE_W){s_sample[csv_pkg::SAMPLE_W-1]}},
                         s_sample};
  assign run_sum_next = (pos_i == '0) ? sample_ext : csv_pkg::sat_add(run_sum, sample_ext);

  assign q_sum          = run_sum_next;
  assign q_i            = pos_i;
  assign q_addr         = PAW'(int'(pos_m) * MAX_INNER + int'(pos_i));
  assign q_flags.m_zero = (pos_m == '0);
  assign q_flags.o_zero = (pos_o == '0);
  assign q_flags.last   = (pos_i == last_i) && (pos_m == last_m) && (pos_o == last_o);

  always_comb begin
    pos_i_next = pos_i;
    pos_m_next = pos_m;
    pos_o_next = pos_o;
    if (pos_i != last_i) begin
      pos_i_next = pos_i + IPW'(1);
    end else begin
      pos_i_next = '0;
      if (pos_m != last_m) begin
        pos_m_next = pos_m + MPW'(1);
      end else begin
        pos_m_next = '0;
        pos_o_next = (pos_o != last_o) ? pos_o + OPW'(1) : '0;
      end
    end
  end

  always_comb begin
    case (cfg_index)
      csv_pkg::REG_INNER:  cfg_hit = cfg_we;
      csv_pkg::REG_MIDDLE: cfg_hit = cfg_we;
      csv_pkg::REG_OUTER:  cfg_hit = cfg_we;
      default:             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_size  <= csv_pkg::CFG_W'(256);
      middle_size <= csv_pkg::CFG_W'(1);
      outer_size  <= csv_pkg::CFG_W'(1);
      run_sum     <= '0;
      pos_i       <= '0;
      pos_m       <= '0;
      pos_o       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csv_pkg::REG_INNER:  inner_size  <= cfg_data;
          csv_pkg::REG_MIDDLE: middle_size <= cfg_data;
          csv_pkg::REG_OUTER:  outer_size  <= cfg_data;
          default: begin
          end
        endcase
      end
      // A register write restarts the array at element zero.
      if (cfg_hit) begin
        run_sum <= '0;
        pos_i   <= '0;
        pos_m   <= '0;
        pos_o   <= '0;
      end else if (accept) begin
        run_sum <= run_sum_next;
        pos_i   <= pos_i_next;
        pos_m   <= pos_m_next;
        pos_o   <= pos_o_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csv_back.sv
// Back part: column line and plane store read-modify-write pipeline plus
// output buffer. Depends on csv_pkg, csv_ram and csv_fifo.
`default_nettype none

module csv_back #(
  parameter int MAX_INNER  = 256,
  parameter int MAX_MIDDLE = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  csv_pkg::sum_t                          q_sum,
  input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] q_i,
  input  logic [((MAX_INNER*MAX_MIDDLE > 1) ? $clog2(MAX_INNER*MAX_MIDDLE) : 1)-1:0] q_addr,
  input  csv_pkg::item_flags_t                   q_flags,
  output logic                                   m_valid,
  input  logic                                   m_ready,
  output csv_pkg::sum_t                          m_sum,
  output logic                                   m_last,
  output csv_pkg::back_status_t                  status
);

  localparam int IPW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int PDEPTH = MAX_INNER * MAX_MIDDLE;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int OCW    = $clog2(csv_pkg::OUT_DEPTH+1);
  localparam int OW     = csv_pkg::SUM_W + 1;

  // Stage 1: column line update.
  logic                 v1;
  csv_pkg::sum_t        p1_sum;
  logic [IPW-1:0]       p1_i;
  logic [PAW-1:0]       p1_addr;
  csv_pkg::item_flags_t p1_flags;
  logic                 col_fwd_hit;
  csv_pkg::sum_t        col_fwd_val;
  csv_pkg::sum_t        col_rd;
  csv_pkg::sum_t        col_base;
  csv_pkg::sum_t        c1;

  // Stage 2: plane store update.
  logic                 v2;
  csv_pkg::sum_t        p2_c;
  logic [PAW-1:0]       p2_addr;
  logic                 p2_o_zero;
  logic                 p2_last;
  logic                 plane_fwd_hit;
  csv_pkg::sum_t        plane_fwd_val;
  csv_pkg::sum_t        plane_rd;
  csv_pkg::sum_t        plane_base;
  csv_pkg::sum_t        y2;

  logic [OCW-1:0]       out_level;
  logic                 out_room;
  logic [OW-1:0]        out_data;
  logic                 pop;
  logic                 credit_ok;

  // Pop only when the output buffer has room for everything in flight.
  assign credit_ok = (32'(out_level) + 32'(v1) + 32'(v2)) < 32'(csv_pkg::OUT_DEPTH);
  assign pop       = q_valid && credit_ok;
  assign q_ready   = credit_ok;

  assign col_base   = col_fwd_hit ? col_fwd_val : col_rd;
  assign c1         = p1_flags.m_zero ? p1_sum : csv_pkg::sat_add(col_base, p1_sum);
  assign plane_base = plane_fwd_hit ? plane_fwd_val : plane_rd;
  assign y2         = p2_o_zero ? p2_c : csv_pkg::sat_add(plane_base, p2_c);

  csv_ram #(.WIDTH(csv_pkg::SUM_W), .DEPTH(MAX_INNER)) u_col_line (
    .clk   (clk),
    .we    (v1),
    .waddr (p1_i),
    .wdata (c1),
    .raddr (q_i),
    .rdata (col_rd)
  );

  csv_ram #(.WIDTH(csv_pkg::SUM_W), .DEPTH(PDEPTH)) u_plane_store (
    .clk   (clk),
    .we    (v2),
    .waddr (p2_addr),
    .wdata (y2),
    .raddr (p1_addr),
    .rdata (plane_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      col_fwd_hit   <= 1'b0;
      plane_fwd_hit <= 1'b0;
    end else begin
      v1            <= pop;
      v2            <= v1;
      // Read of an entry that is being written: take the fresh value.
      col_fwd_hit   <= pop && v1 && (q_i == p1_i);
      plane_fwd_hit <= v1 && v2 && (p1_addr == p2_addr);
    end
  end

  always_ff @(posedge clk) begin
    p1_sum        <= q_sum;
    p1_i          <= q_i;
    p1_addr       <= q_addr;
    p1_flags      <= q_flags;
    col_fwd_val   <= c1;
    p2_c          <= c1;
    p2_addr       <= p1_addr;
    p2_o_zero     <= p1_flags.o_zero;
    p2_last       <= p1_flags.last;
    plane_fwd_val <= y2;
  end

  csv_fifo #(.WIDTH(OW), .DEPTH(csv_pkg::OUT_DEPTH)) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (out_room),
    .in_data   ({p2_last, y2}),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_data  (out_data),
    .level     (out_level)
  );

  assign m_sum  = out_data[csv_pkg::SUM_W-1:0];
  assign m_last = out_data[csv_pkg::SUM_W];

  assign status.pop      = pop;
  assign status.q_valid  = q_valid;
  assign status.out_push = v2;
  assign status.out_room = out_room;

endmodule

`default_nettype wire

FILE: rtl/cumulative_sum_volume.sv
// Top level of cumulative_sum_volume: front part, queue, back part.
// Depends on csv_pkg, csv_front, csv_fifo, csv_back and the macros header.
//
//   channel   dir   handshake                 payload
//   s_axis    in    s_axis_tvalid/tready      tdata[15:0] sample
//   m_axis    out   m_axis_tvalid/tready      tdata[47:0] cum_sum, tlast last_of_volume
//   cfg       in    cfg_we (no wait)          cfg_index, cfg_data[8:0]
//
// Sustained rate is one beat per cycle on both sides while m_axis_tready is high;
// a beat passes the queue, column stage, plane stage and output buffer in order.
// Column line and plane store each take one read and one write per cycle, with a
// one-item bypass for the same-entry case. Reset is synchronous and clears
// counters, running sum and queues; the stores are not cleared and need no sweep.
// An output stall fills the output buffer, then the back part holds the queue,
// and s_axis_tready drops once the four-entry queue is full.
`default_nettype none
`include "cumulative_sum_volume_macros.svh"

module cumulative_sum_volume #(
  parameter int MAX_INNER  = 256,
  parameter int MAX_MIDDLE = 256,
  parameter int MAX_OUTER  = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] cum_sum
  output logic        m_axis_tlast,   // last_of_volume
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int IPW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int PAW = (MAX_INNER*MAX_MIDDLE > 1) ? $clog2(MAX_INNER*MAX_MIDDLE) : 1;
  localparam int FW  = $bits(csv_pkg::item_flags_t);
  localparam int QW  = csv_pkg::SUM_W + IPW + PAW + FW;
  localparam int QDEPTH = 4;
  localparam int QLW = $clog2(QDEPTH+1);

  // Front side of the queue.
  logic                 fq_valid;
  logic                 fq_ready;
  csv_pkg::sum_t        fq_sum;
  logic [IPW-1:0]       fq_i;
  logic [PAW-1:0]       fq_addr;
  csv_pkg::item_flags_t fq_flags;

  // Back side of the queue.
  logic                 bq_valid;
  logic                 bq_ready;
  logic [QW-1:0]        bq_data;
  csv_pkg::sum_t        bq_sum;
  logic [IPW-1:0]       bq_i;
  logic [PAW-1:0]       bq_addr;
  csv_pkg::item_flags_t bq_flags;
  logic [QLW-1:0]       q_level;

  csv_pkg::sum_t         out_sum;
  csv_pkg::back_status_t back_status;

  csv_front #(
    .MAX_INNER  (MAX_INNER),
    .MAX_MIDDLE (MAX_MIDDLE),
    .MAX_OUTER  (MAX_OUTER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_sample  (s_axis_tdata),
    .q_ready   (fq_ready),
    .q_valid   (fq_valid),
    .q_sum     (fq_sum),
    .q_i       (fq_i),
    .q_addr    (fq_addr),
    .q_flags   (fq_flags)
  );

  // Decouple classification from the store updates.
  csv_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   ({fq_flags, fq_addr, fq_i, fq_sum}),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data),
    .level     (q_level)
  );

  assign {bq_flags, bq_addr, bq_i, bq_sum} = bq_data;

  csv_back #(
    .MAX_INNER  (MAX_INNER),
    .MAX_MIDDLE (MAX_MIDDLE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_sum   (bq_sum),
    .q_i     (bq_i),
    .q_addr  (bq_addr),
    .q_flags (bq_flags),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_sum   (out_sum),
    .m_last  (m_axis_tlast),
    .status  (back_status)
  );

  assign m_axis_tdata = out_sum;

  // Credit logic must keep the output buffer from overflowing.
  `CSV_ASSERT(a_out_no_overflow, !(back_status.out_push && !back_status.out_room))
  // The back part pops only a beat the queue really holds.
  `CSV_ASSERT(a_pop_has_beat, !(back_status.pop && !back_status.q_valid))
  // The queue never holds more than its depth.
  `CSV_ASSERT(a_queue_bound, q_level <= QLW'(QDEPTH))
  // Nothing leaves in the first cycle after reset.
  `CSV_ASSERT_IMPL(a_quiet_after_reset, $past(rst), !m_axis_tvalid)

endmodule

`default_nettype wire

FILE: tb/sv/cumulative_sum_volume_checker.sv
// Scoreboard for cumulative_sum_volume: watches the config port and both streams.
// Predicts each output beat from the accepted samples and compares cum_sum and tlast.
// Depends on csv_pkg for the register index names.
`timescale 1ns / 1ps

module cumulative_sum_volume_checker #(
  parameter int MAX_INNER  = 256,
  parameter int MAX_MIDDLE = 256,
  parameter int MAX_OUTER  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [47:0] cum_sum
  input  logic        m_axis_tlast,   // last_of_volume
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          outstanding,
  output int          failures
);

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [47:0] cum_sum;
    logic        last_of_volume;
  } volume_sum_t;

  volume_sum_t expected_sums[$];

  logic [8:0]  inner_reg, middle_reg, outer_reg;
  longint      row_sum;
  longint      col_sums[MAX_INNER];
  longint      plane_sums[MAX_INNER*MAX_MIDDLE];
  int unsigned pos_i, pos_m, pos_o;
  int          fail_count = 0;

  // Zero acts as one; anything past the maximum acts as the maximum.
  function automatic int unsigned clamp_size(logic [8:0] raw, int unsigned cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic longint sat_sum(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic void restart_volume();
    row_sum = 0;
    pos_i = 0;
    pos_m = 0;
    pos_o = 0;
  endfunction

  // Row sum, then column sum per inner position, then plane sum per (m, i).
  function automatic volume_sum_t accumulate_sample(logic [15:0] smp);
    int unsigned ni, nm, no, idx;
    longint      x, r, c, y;
    volume_sum_t res;
    ni = clamp_size(inner_reg, MAX_INNER);
    nm = clamp_size(middle_reg, MAX_MIDDLE);
    no = clamp_size(outer_reg, MAX_OUTER);
    x = longint'($signed(smp));
    r = (pos_i == 0) ? x : sat_sum(row_sum + x);
    row_sum = r;
    c = (pos_m == 0) ? r : sat_sum(col_sums[pos_i] + r);
    col_sums[pos_i] = c;
    idx = pos_m * MAX_INNER + pos_i;
    y = (pos_o == 0) ? c : sat_sum(plane_sums[idx] + c);
    plane_sums[idx] = y;
    res.cum_sum = y[47:0];
    res.last_of_volume = (pos_i == ni - 1) && (pos_m == nm - 1) && (pos_o == no - 1);
    if (pos_i + 1 < ni) begin
      pos_i++;
    end else begin
      pos_i = 0;
      if (pos_m + 1 < nm) begin
        pos_m++;
      end else begin
        pos_m = 0;
        pos_o = (pos_o + 1 < no) ? pos_o + 1 : 0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    volume_sum_t want;
    if (rst) begin
      inner_reg = 9'd256;
      middle_reg = 9'd1;
      outer_reg = 9'd1;
      restart_volume();
      expected_sums.delete();
      outstanding <= 0;
    end else begin
      // Any valid index restarts the volume; the spare index is ignored.
      if (cfg_we) begin
        case (cfg_index)
          csv_pkg::REG_INNER: begin
            inner_reg = cfg_data;
            restart_volume();
          end
          csv_pkg::REG_MIDDLE: begin
            middle_reg = cfg_data;
            restart_volume();
          end
          csv_pkg::REG_OUTER: begin
            outer_reg = cfg_data;
            restart_volume();
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $error("output beat with no sample pending: cum_sum %0d, tlast %0b",
                 $signed(m_axis_tdata), m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata !== want.cum_sum) begin
            $error("cum_sum mismatch: expected %0d, actual %0d",
                   $signed(want.cum_sum), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tlast !== want.last_of_volume) begin
            $error("last_of_volume mismatch: expected %0b, actual %0b",
                   want.last_of_volume, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_sums.push_back(accumulate_sample(s_axis_tdata));
      outstanding <= expected_sums.size();
    end
    failures <= fail_count;
  end

endmodule

FILE: tb/sv/tb_cumulative_sum_volume.sv
// Top of the cumulative_sum_volume testbench: clock, reset, stimulus and verdict.
// Instantiates the block and cumulative_sum_volume_checker; uses csv_pkg names.
`timescale 1ns / 1ps

module tb_cumulative_sum_volume;

  // Index 3 maps to no register; a write there must leave the volume alone.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int RANDOM_SAMPLES  = 700;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [47:0] m_axis_tdata;
  wire         m_axis_tlast;

  int          outstanding;
  int          failures;
  int          cycle_count = 0;
  int          samples_sent = 0;
  int          burst_left = 0;
  bit          gapless = 1'b0;
  bit          hold_off_request = 1'b0;

  always #6 clk = ~clk;

  cumulative_sum_volume u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cumulative_sum_volume_checker u_checker (.*);

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: switch between stall patterns after each random-length segment. A hold-off
  // request parks tready low for a long stretch so the block backs up into its
  // input queue and drops s_axis_tready.
  initial begin
    int seg, mode, period;
    forever begin
      seg = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      period = $urandom_range(2, 6);
      for (int k = 0; k < seg; k++) begin
        @(posedge clk);
        if (hold_off_request) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off_request = 1'b0;
        end
        case (mode)
          0: m_axis_tready <= 1'b1;                         // no stalls
          1: m_axis_tready <= 1'($urandom_range(0, 1));    // coin flip
          2: m_axis_tready <= (k % period) != 0;            // periodic bubble
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted. Bursts of random length are
  // separated by random gaps, short or long; gapless mode keeps valid high.
  task automatic send_sample(input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 :
            ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One write per call; the trailing edge keeps back-to-back writes apart.
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] inner, input logic [8:0] middle,
                           input logic [8:0] outer);
    settle();
    write_reg(csv_pkg::REG_INNER, inner);
    write_reg(csv_pkg::REG_MIDDLE, middle);
    write_reg(csv_pkg::REG_OUTER, outer);
  endtask

  // Mix full-scale values with small magnitudes and plain random words.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF - 16'($urandom_range(0, 15));
      3: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int span(logic [8:0] raw);
    return (raw == 0) ? 1 : int'(raw);
  endfunction

  initial begin
    int phase, count, vol, axis, big, first_random;
    logic [8:0] ri, rm, ro;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes give a 256-long line: walk the extremes of the sample.
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);

    // Zero inner size acts as one: a 1x2x2 volume at full scale, then wrap
    // into a fresh volume.
    configure(9'd0, 9'd2, 9'd2);
    repeat (4) send_sample(16'h7FFF);
    repeat (2) send_sample(16'h8000);

    // Write to the spare index mid-volume: the volume must carry on.
    configure(9'd3, 9'd2, 9'd1);
    send_sample(16'h1234);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    settle();
    write_reg(REG_NONE, 9'h1FF);
    send_sample(16'hFFFF);
    send_sample(16'h0100);
    send_sample(16'hFF00);

    // Outer size beyond the maximum clamps to 256.
    configure(9'd2, 9'd1, 9'd511);
    repeat (2) send_sample(16'h8000);
    repeat (2) send_sample(16'h7FFF);

    // Random volumes: mostly small shapes, one long run along a single
    // axis at or past the maximum size.
    first_random = samples_sent;
    phase = 0;
    while (samples_sent - first_random < RANDOM_SAMPLES) begin
      if (phase == 3) begin
        axis = $urandom_range(0, 2);
        big = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
        case (axis)
          0: configure(9'(big), 9'd1, 9'd1);
          1: configure(9'd1, 9'(big), 9'd1);
          default: configure(9'd1, 9'd1, 9'(big));
        endcase
        count = 256 + $urandom_range(1, 5);
      end else begin
        ri = 9'($urandom_range(0, 8));
        rm = 9'($urandom_range(0, 4));
        ro = 9'($urandom_range(0, 4));
        configure(ri, rm, ro);
        vol = span(ri) * span(rm) * span(ro);
        count = vol * $urandom_range(1, 2);
        // Extend some runs so the next write restarts a partial volume.
        if ($urandom_range(0, 2) == 0) count += $urandom_range(1, vol);
      end
      // Back up the block: stall the receiver while the sender keeps going.
      if (phase == 1) begin
        gapless = 1'b1;
        hold_off_request = 1'b1;
        if (count < 48) count = 48;
      end
      for (int k = 0; k < count; k++) begin
        send_sample(pick_sample());
        // Pause the sender until the block runs dry, mid-volume.
        if ((phase == 5 && k == count / 2) || $urandom_range(0, 99) == 0) settle();
      end
      gapless = 1'b0;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/csv_pkg.sv
rtl/csv_ram.sv
rtl/csv_fifo.sv
rtl/csv_front.sv
rtl/csv_back.sv
rtl/cumulative_sum_volume.sv
tb/sv/cumulative_sum_volume_checker.sv
tb/sv/tb_cumulative_sum_volume.sv
